// ===== src/rrol_pkg.sv =====
// Shared types and constants for the record ring with offset lookup.
// Used by rrol_mem, rrol_ctrl and record_ring_with_offset_lookup; no dependencies.
package rrol_pkg;

    localparam int HANDLE_W     = 32;
    localparam int LENGTH_W     = 20;
    localparam int OFFSET_W     = 24;
    localparam int SLOT_FIELD_W = 4;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FIND = 1'b1;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LENGTH_W-1:0] length;
    } desc_t;

    typedef struct packed {
        logic                    hit;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [HANDLE_W-1:0]     handle;
        logic [LENGTH_W-1:0]     byte_pos;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_WALK,
        ST_DONE
    } ctrl_state_t;

endpackage

// ===== src/rrol_mem.sv =====
// Descriptor memory: one write port, one read port, registered read data.
// Depends on rrol_pkg for desc_t.
module rrol_mem #(
    parameter int SLOTS = 16
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(SLOTS)-1:0]  waddr,
    input  rrol_pkg::desc_t           wdata,
    input  logic [$clog2(SLOTS)-1:0]  raddr,
    output rrol_pkg::desc_t           rdata
);
    import rrol_pkg::*;

    desc_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/rrol_ctrl.sv =====
// Sequencer for the record ring: slot pointers, add read-modify-write, offset walk.
// Depends on rrol_pkg; drives the ports of rrol_mem.
module rrol_ctrl #(
    parameter int SLOTS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   in_action,
    input  logic [rrol_pkg::HANDLE_W-1:0]          in_handle,
    input  logic [rrol_pkg::LENGTH_W-1:0]          in_length,
    input  logic [rrol_pkg::OFFSET_W-1:0]          in_offset,
    output logic                                   mem_we,
    output logic [$clog2(SLOTS)-1:0]               mem_waddr,
    output rrol_pkg::desc_t                        mem_wdata,
    output logic [$clog2(SLOTS)-1:0]               mem_raddr,
    input  rrol_pkg::desc_t                        mem_rdata,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output rrol_pkg::result_t                      res
);
    import rrol_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    function automatic logic [SW-1:0] step_slot(input logic [SW-1:0] s);
        step_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SW-1:0] s);
        logic [SW+SLOT_FIELD_W-1:0] ext;
        ext = {{SLOT_FIELD_W{1'b0}}, s};
        slot_field = ext[SLOT_FIELD_W-1:0];
    endfunction

    ctrl_state_t         state_reg,   state_next;
    logic [SW-1:0]       wr_slot_reg, wr_slot_next;
    logic [SW-1:0]       rd_slot_reg, rd_slot_next;
    logic                full_reg,    full_next;
    logic [SW-1:0]       cur_reg,     cur_next;
    logic [OFFSET_W-1:0] off_reg,     off_next;
    desc_t               desc_reg,    desc_next;
    logic                find_reg,    find_next;
    result_t             res_reg,     res_next;

    logic [SW-1:0]       cur_step;
    logic [OFFSET_W-1:0] len_ext;

    assign cur_step = step_slot(cur_reg);
    assign len_ext  = {{(OFFSET_W-LENGTH_W){1'b0}}, mem_rdata.length};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wr_slot_reg <= '0;
            rd_slot_reg <= '0;
            full_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
            full_reg    <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        off_reg  <= off_next;
        desc_reg <= desc_next;
        find_reg <= find_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        full_next    = full_reg;
        cur_next     = cur_reg;
        off_next     = off_reg;
        desc_next    = desc_reg;
        find_next    = find_reg;
        res_next     = res_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = cur_reg;
        mem_wdata    = desc_reg;
        mem_raddr    = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                mem_raddr = (in_action == ACT_FIND) ? rd_slot_reg : wr_slot_reg;
                if (in_valid)
                begin
                    find_next   = (in_action == ACT_FIND);
                    off_next    = in_offset;
                    desc_next   = '{handle: in_handle, length: in_length};
                    if (in_action == ACT_ADD)
                    begin
                        cur_next   = wr_slot_reg;
                        state_next = ST_ADD;
                    end
                    else if (wr_slot_reg != rd_slot_reg || full_reg)
                    begin
                        cur_next   = rd_slot_reg;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        // empty ring: miss
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_ADD:
            begin
                // old entry was read on accept; overwrite it now
                mem_we            = 1'b1;
                res_next.hit      = full_reg;
                res_next.slot     = slot_field(cur_reg);
                res_next.handle   = full_reg ? mem_rdata.handle : '0;
                res_next.byte_pos = '0;
                wr_slot_next      = cur_step;
                if (full_reg)
                begin
                    rd_slot_next = cur_step;
                end
                else if (cur_step == rd_slot_reg)
                begin
                    full_next = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_WALK:
            begin
                // prefetch the next record while testing this one
                mem_raddr = cur_step;
                if (off_reg < len_ext)
                begin
                    res_next.hit      = 1'b1;
                    res_next.slot     = slot_field(cur_reg);
                    res_next.handle   = mem_rdata.handle;
                    res_next.byte_pos = off_reg[LENGTH_W-1:0];
                    state_next        = ST_DONE;
                end
                else
                begin
                    off_next = off_reg - len_ext;
                    if (cur_step == wr_slot_reg)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cur_next = cur_step;
                    end
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_full_meets: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (wr_slot_reg == rd_slot_reg))
        else $error("ring full but slot indices differ");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (wr_slot_reg != rd_slot_reg || full_reg))
        else $error("walking an empty ring");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wr_slot_reg} < (SW+1)'(SLOTS)) && ({1'b0, rd_slot_reg} < (SW+1)'(SLOTS)))
        else $error("slot index beyond ring depth");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && find_reg && !res_reg.hit) |->
            (res_reg.handle == '0 && res_reg.byte_pos == '0 && res_reg.slot == '0))
        else $error("find miss carries nonzero fields");

    a_add_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |=> (wr_slot_reg == step_slot($past(wr_slot_reg))))
        else $error("add did not advance write slot");

endmodule

// ===== src/record_ring_with_offset_lookup.sv =====
// Top level of the record ring with offset lookup: stream ports and output register.
// Depends on rrol_pkg, rrol_mem and rrol_ctrl.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_axis   | in  | record_handle[32] record_length[20]         | action
//           |     | byte_offset[24] zero pad[4]                 |
//  m_axis   | out | slot[4] handle_out[32] byte_in_record[20]   | hit
//
// An add goes from accept through a memory read of the slot and a write-back to the result.
// A find walks k records, where k is 1 to SLOTS;
// the walk reads one length per cycle from the descriptor memory's single read port.
// An empty-ring find walks no records. One item is in work at a time.
// Reset clears the slot indices and full flag; memory contents stay undefined until written.
// The output register lets a new item be accepted while a result waits on m_axis_tready.
module record_ring_with_offset_lookup #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // record_handle, record_length, byte_offset, pad
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // slot, handle_out, byte_in_record
    output logic [0:0]  m_axis_tuser    // hit
);
    import rrol_pkg::*;

    localparam int SW = $clog2(SLOTS);

    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    desc_t         mem_wdata;
    logic [SW-1:0] mem_raddr;
    desc_t         mem_rdata;
    logic          res_valid;
    logic          res_ready;
    result_t       res;

    logic          out_valid_reg, out_valid_next;
    result_t       out_reg,       out_next;

    rrol_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rrol_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser[0]),
        .in_handle (s_axis_tdata[31:0]),
        .in_length (s_axis_tdata[51:32]),
        .in_offset (s_axis_tdata[75:52]),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tuser[0] = out_reg.hit;
    assign m_axis_tdata    = {out_reg.byte_pos, out_reg.handle, out_reg.slot};

endmodule

// ===== tb/sv/rrol_stream_checker.sv =====
// Checker for the record ring with offset lookup: watches both stream channels,
// predicts every result from accepted items and compares it field by field.
// Depends on rrol_pkg.
module rrol_stream_checker #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // record_handle, record_length, byte_offset, pad
    input  logic [0:0]  s_axis_tuser,   // action
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // slot, handle_out, byte_in_record
    input  logic [0:0]  m_axis_tuser,   // hit
    output int          error_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import rrol_pkg::*;

    localparam int MAX_REPORTS = 10;

    logic [HANDLE_W-1:0] ring_handle [SLOTS];
    logic [LENGTH_W-1:0] ring_length [SLOTS];
    int unsigned         wr_slot;
    int unsigned         rd_slot;
    bit                  ring_full;
    result_t             expected_results [$];
    int                  reported;

    // Apply one item to the shadow ring and work out the result it produces.
    task automatic predict_ring_op(
        input  logic                act,
        input  logic [HANDLE_W-1:0] handle,
        input  logic [LENGTH_W-1:0] length,
        input  logic [OFFSET_W-1:0] offset,
        output result_t             res
    );
        int unsigned         idx;
        logic [OFFSET_W-1:0] remaining;
        res = '0;
        if (act == ACT_ADD) begin
            if (ring_full) begin
                res.hit    = 1'b1;
                res.handle = ring_handle[wr_slot];
            end
            ring_handle[wr_slot] = handle;
            ring_length[wr_slot] = length;
            res.slot = SLOT_FIELD_W'(wr_slot);
            wr_slot = (wr_slot + 1) % SLOTS;
            // read slot follows the write slot once the oldest record is being overwritten
            if (ring_full)
                rd_slot = wr_slot;
            else if (wr_slot == rd_slot)
                ring_full = 1'b1;
        end
        else if (wr_slot != rd_slot || ring_full) begin
            idx       = rd_slot;
            remaining = offset;
            for (int n = 0; n < SLOTS; n++) begin
                if (remaining < OFFSET_W'(ring_length[idx])) begin
                    res.hit      = 1'b1;
                    res.slot     = SLOT_FIELD_W'(idx);
                    res.handle   = ring_handle[idx];
                    res.byte_pos = LENGTH_W'(remaining);
                    break;
                end
                remaining = remaining - OFFSET_W'(ring_length[idx]);
                idx = (idx + 1) % SLOTS;
                if (idx == wr_slot)
                    break;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        result_t fresh;
        if (!rst_n) begin
            wr_slot     = 0;
            rd_slot     = 0;
            ring_full   = 1'b0;
            reported    = 0;
            error_count = 0;
            expected_results.delete();
        end
        else begin
            // check results before queuing new expectations from the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit      = m_axis_tuser[0];
                got.slot     = m_axis_tdata[3:0];
                got.handle   = m_axis_tdata[35:4];
                got.byte_pos = m_axis_tdata[55:36];
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (reported < MAX_REPORTS) begin
                        reported++;
                        $display("unexpected item on m_axis: hit=%0d slot=%0d handle=%h byte=%0d",
                                 got.hit, got.slot, got.handle, got.byte_pos);
                    end
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit || got.slot !== want.slot ||
                        got.handle !== want.handle || got.byte_pos !== want.byte_pos) begin
                        error_count++;
                        if (reported < MAX_REPORTS) begin
                            reported++;
                            $display("mismatch: expected hit=%0d slot=%0d handle=%h byte=%0d",
                                     want.hit, want.slot, want.handle, want.byte_pos);
                            $display("          got      hit=%0d slot=%0d handle=%h byte=%0d",
                                     got.hit, got.slot, got.handle, got.byte_pos);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_ring_op(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[51:32],
                                s_axis_tdata[75:52], fresh);
                expected_results.push_back(fresh);
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== tb/sv/record_ring_with_offset_lookup_tb.sv =====
// Top of the record ring testbench: clock, reset, stimulus, receiver back-pressure
// and the verdict. Depends on rrol_pkg, record_ring_with_offset_lookup and rrol_stream_checker.
module record_ring_with_offset_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrol_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 650;
    localparam int TAIL_CYCLES  = 2 * SLOTS + 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // record_handle, record_length, byte_offset, pad
    logic [0:0]  s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // slot, handle_out, byte_in_record
    logic [0:0]  m_axis_tuser;   // hit

    int error_count;
    int pending_count;
    int sent_count;
    int taken_count;
    int cycle_count;

    record_ring_with_offset_lookup #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    rrol_stream_checker #(
        .SLOTS(SLOTS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .error_count  (error_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one item after a random gap, or none in back-to-back stretches, and hold it until accepted.
    task automatic offer_item(
        input logic                act,
        input logic [HANDLE_W-1:0] handle,
        input logic [LENGTH_W-1:0] length,
        input logic [OFFSET_W-1:0] offset
    );
        int gap;
        gap = ((sent_count / 50) % 3 == 1) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {4'b0000, offset, length, handle};
        s_axis_tuser  <= act;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sent_count++;
    endtask

    // Receiver: random stall per item, quiet stretches, and one long hold-off.
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        taken_count = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken_count == HOLD_AT)
                stall = HOLD_CYCLES;
            else if ((taken_count / 40) % 3 == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 12);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken_count++;
        end
    end

    initial
    begin
        logic                act;
        logic [LENGTH_W-1:0] length;
        logic [OFFSET_W-1:0] offset;
        int                  pick;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_ADD;
        sent_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // find on an empty ring misses at both offset extremes
        offer_item(ACT_FIND, $urandom(), LENGTH_W'($urandom()), 24'h000000);
        offer_item(ACT_FIND, $urandom(), LENGTH_W'($urandom()), 24'hFFFFFF);
        // zero-length record first, then the largest one, then a one-byte record
        offer_item(ACT_ADD, 32'h0000_0000, 20'h00000, OFFSET_W'($urandom()));
        offer_item(ACT_ADD, 32'hFFFF_FFFF, 20'hFFFFF, OFFSET_W'($urandom()));
        offer_item(ACT_ADD, $urandom(), 20'h00001, OFFSET_W'($urandom()));
        // skip the empty record, hit both ends of the large one, cross into the next
        offer_item(ACT_FIND, $urandom(), LENGTH_W'($urandom()), 24'h000000);
        offer_item(ACT_FIND, $urandom(), LENGTH_W'($urandom()), 24'h0FFFFE);
        offer_item(ACT_FIND, $urandom(), LENGTH_W'($urandom()), 24'h0FFFFF);
        // just past the stored data, and far past it
        offer_item(ACT_FIND, $urandom(), LENGTH_W'($urandom()), 24'h100000);
        offer_item(ACT_FIND, $urandom(), LENGTH_W'($urandom()), 24'hFFFFFF);
        // fill the ring, then overwrite the two oldest records
        for (int i = 0; i < SLOTS - 3; i++)
            offer_item(ACT_ADD, $urandom(), (i % 4 == 0) ? 20'h0 : 20'($urandom_range(1, 32)),
                       OFFSET_W'($urandom()));
        offer_item(ACT_ADD, $urandom(), 20'h00010, OFFSET_W'($urandom()));
        offer_item(ACT_ADD, $urandom(), 20'h00000, OFFSET_W'($urandom()));
        offer_item(ACT_FIND, $urandom(), LENGTH_W'($urandom()), 24'h000000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            act = ($urandom_range(0, 99) < 45) ? ACT_ADD : ACT_FIND;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                length = '0;
            else if (pick == 1)
                length = LENGTH_W'($urandom());
            else if (pick == 2)
                length = '1;
            else
                length = LENGTH_W'($urandom_range(1, 64));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                offset = OFFSET_W'($urandom());
            else if (pick == 1)
                offset = '1;
            else if (pick < 5)
                offset = OFFSET_W'($urandom_range(0, 1 << 21));
            else
                offset = OFFSET_W'($urandom_range(0, 1200));
            offer_item(act, $urandom(), length, offset);
        end
        s_axis_tvalid <= 1'b0;

        // let the checker queue the last accepted item first
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
src/rrol_pkg.sv
src/rrol_mem.sv
src/rrol_ctrl.sv
src/record_ring_with_offset_lookup.sv
tb/sv/rrol_stream_checker.sv
tb/sv/record_ring_with_offset_lookup_tb.sv
